/* sv/pav_pkg.sv */
// Shared types and constants for the pairwise viscosity pipeline.
package pav_pkg;

    // How a word in flight will be finished: computed, forced to zero, or saturated.
    typedef enum logic [1:0] {
        KIND_CALC,
        KIND_ZERO,
        KIND_SAT
    } t_kind;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 2'd2;

    localparam logic [30:0] ALPHA_RESET = 31'd65536;
    localparam logic [30:0] BETA_RESET  = 31'd131072;
    localparam logic [30:0] EPS_RESET   = 31'd655;

    localparam logic [31:0] SAT_VALUE = 32'h7FFF_FFFF;

endpackage

/* sv/pav_div_stage.sv */
// One registered step of a restoring divider, with sideband carried alongside.
module pav_div_stage
    import pav_pkg::*;
#(
    parameter int DW = 32,
    parameter int QW = 31,
    parameter int SW = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_nq,
    input  logic [DW-1:0] i_dvs,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_rem,
    output logic [QW-1:0] o_nq,
    output logic [DW-1:0] o_dvs,
    output logic [SW-1:0] o_side
);

    logic          r_valid;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_nq;
    logic [DW-1:0] r_dvs;
    logic [SW-1:0] r_side;

    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;
    logic [DW-1:0] n_rem;
    logic [QW-1:0] n_nq;

    // Numerator bits leave at the top while quotient bits enter at the bottom.
    always_comb begin
        trial = {i_rem, i_nq[QW-1]};
        ge    = trial >= {1'b0, i_dvs};
        diff  = trial - {1'b0, i_dvs};
        n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
        n_nq  = {i_nq[QW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_nq   <= n_nq;
            r_dvs  <= i_dvs;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_nq    = r_nq;
    assign o_dvs   = r_dvs;
    assign o_side  = r_side;

endmodule

/* sv/pav_front.sv */
// Front end: dot products, averages, numerator and denominator of mu, divider setup.
module pav_front
    import pav_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int MUW       = 79,
    parameter int DENW      = 96
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic signed [31:0] i_rel_pos_x,
    input  logic signed [31:0] i_rel_pos_y,
    input  logic signed [31:0] i_rel_pos_z,
    input  logic signed [31:0] i_rel_vel_x,
    input  logic signed [31:0] i_rel_vel_y,
    input  logic signed [31:0] i_rel_vel_z,
    input  logic [30:0]       i_smooth_len_i,
    input  logic [30:0]       i_smooth_len_j,
    input  logic [30:0]       i_sound_i,
    input  logic [30:0]       i_sound_j,
    input  logic [30:0]       i_dens_i,
    input  logic [30:0]       i_dens_j,
    input  logic [30:0]       i_eps,
    input  logic              i_ab_zero,
    output logic              o_valid,
    output logic [DENW-1:0]   o_rem,
    output logic [MUW-1:0]    o_num,
    output logic [DENW-1:0]   o_den,
    output logic [31:0]       o_cs,
    output logic [31:0]       o_ds,
    output t_kind             o_kind
);

    localparam int NUMW = 97 + FRAC_BITS;
    localparam int HIW  = NUMW - MUW;

    function automatic logic [31:0] mag(input logic [31:0] x);
        mag = x[31] ? (~x + 32'd1) : x;
    endfunction

    logic [31:0] pos_in [3];
    logic [31:0] vel_in [3];

    assign pos_in[0] = i_rel_pos_x;
    assign pos_in[1] = i_rel_pos_y;
    assign pos_in[2] = i_rel_pos_z;
    assign vel_in[0] = i_rel_vel_x;
    assign vel_in[1] = i_rel_vel_y;
    assign vel_in[2] = i_rel_vel_z;

    // Stage 1: magnitudes, sign of each product, sums of the pair quantities.
    logic [31:0] n1_mr [3];
    logic [31:0] n1_mv [3];
    logic [2:0]  n1_sg;
    logic [31:0] n1_cs_raw;
    logic [31:0] n1_cs;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n1_mr[k] = mag(pos_in[k]);
            n1_mv[k] = mag(vel_in[k]);
            n1_sg[k] = pos_in[k][31] ^ vel_in[k][31];
        end
        n1_cs_raw = {1'b0, i_sound_i} + {1'b0, i_sound_j};
        n1_cs     = (n1_cs_raw < 32'd2) ? 32'd2 : n1_cs_raw;
    end

    logic        r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v;
    logic [31:0] r1_mr [3];
    logic [31:0] r1_mv [3];
    logic [2:0]  r1_sg;
    logic [31:0] r1_hs, r1_cs, r1_ds;

    logic [63:0] r2_p [3];
    logic [63:0] r2_q [3];
    logic [2:0]  r2_sg;
    logic [31:0] r2_hs, r2_cs, r2_ds;

    logic [63:0] r3_pos, r3_neg, r3_rr;
    logic [31:0] r3_hs, r3_cs, r3_ds;

    logic [63:0] r4_m, r4_rr;
    logic [31:0] r4_hs, r4_cs, r4_ds;
    t_kind       r4_kind;

    logic [63:0] r5_hm_lo, r5_hm_hi, r5_hh, r5_rr;
    logic [31:0] r5_cs, r5_ds;
    t_kind       r5_kind;

    logic [NUMW-1:0] r6_num;
    logic [63:0]     r6_e_lo, r6_e_hi, r6_rr;
    logic [31:0]     r6_cs, r6_ds;
    t_kind           r6_kind;

    logic [NUMW-1:0] r7_num;
    logic [DENW-1:0] r7_den;
    logic [31:0]     r7_cs, r7_ds;
    t_kind           r7_kind;

    logic [DENW-1:0] r8_rem;
    logic [MUW-1:0]  r8_num;
    logic [DENW-1:0] r8_den;
    logic [31:0]     r8_cs, r8_ds;
    t_kind           r8_kind;

    // Stage 3: split the dot product into its positive and negative parts.
    logic [63:0] n3_pos, n3_neg, n3_rr;

    always_comb begin
        n3_pos = '0;
        n3_neg = '0;
        n3_rr  = '0;
        for (int k = 0; k < 3; k++) begin
            if (r2_sg[k]) begin
                n3_neg = n3_neg + r2_p[k];
            end else begin
                n3_pos = n3_pos + r2_p[k];
            end
            n3_rr = n3_rr + r2_q[k];
        end
        if (n3_rr == 64'd0) begin
            n3_rr = 64'd1;
        end
    end

    t_kind n4_kind;

    always_comb begin
        if (r3_neg <= r3_pos) begin
            n4_kind = KIND_ZERO;
        end else if (r3_ds == 32'd0) begin
            n4_kind = KIND_SAT;
        end else begin
            n4_kind = KIND_CALC;
        end
    end

    logic [NUMW-1:0] n6_num;
    logic [DENW-1:0] n7_den;
    logic [HIW-1:0]  n8_hi;
    logic            n8_ovf;
    t_kind           n8_kind;

    always_comb begin
        n6_num = ((NUMW'(r5_hm_hi) << 32) + NUMW'(r5_hm_lo)) << (FRAC_BITS + 1);
        n7_den = (DENW'(r6_rr) << (FRAC_BITS + 2)) + DENW'(r6_e_lo)
               + (DENW'(r6_e_hi) << 32);
        n8_hi  = r7_num[NUMW-1:MUW];
        // A quotient that does not fit in MUW bits is past every saturation limit.
        n8_ovf = DENW'(n8_hi) >= r7_den;
        if (r7_kind == KIND_CALC && n8_ovf) begin
            n8_kind = i_ab_zero ? KIND_ZERO : KIND_SAT;
        end else begin
            n8_kind = r7_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mr <= n1_mr;
            r1_mv <= n1_mv;
            r1_sg <= n1_sg;
            r1_hs <= {1'b0, i_smooth_len_i} + {1'b0, i_smooth_len_j};
            r1_cs <= n1_cs;
            r1_ds <= {1'b0, i_dens_i} + {1'b0, i_dens_j};

            for (int k = 0; k < 3; k++) begin
                r2_p[k] <= 64'(r1_mr[k]) * 64'(r1_mv[k]);
                r2_q[k] <= 64'(r1_mr[k]) * 64'(r1_mr[k]);
            end
            r2_sg <= r1_sg;
            r2_hs <= r1_hs;
            r2_cs <= r1_cs;
            r2_ds <= r1_ds;

            r3_pos <= n3_pos;
            r3_neg <= n3_neg;
            r3_rr  <= n3_rr;
            r3_hs  <= r2_hs;
            r3_cs  <= r2_cs;
            r3_ds  <= r2_ds;

            r4_m    <= r3_neg - r3_pos;
            r4_rr   <= r3_rr;
            r4_hs   <= r3_hs;
            r4_cs   <= r3_cs;
            r4_ds   <= r3_ds;
            r4_kind <= n4_kind;

            r5_hm_lo <= 64'(r4_hs) * 64'(r4_m[31:0]);
            r5_hm_hi <= 64'(r4_hs) * 64'(r4_m[63:32]);
            r5_hh    <= 64'(r4_hs) * 64'(r4_hs);
            r5_rr    <= r4_rr;
            r5_cs    <= r4_cs;
            r5_ds    <= r4_ds;
            r5_kind  <= r4_kind;

            r6_num  <= n6_num;
            r6_e_lo <= 64'(i_eps) * 64'(r5_hh[31:0]);
            r6_e_hi <= 64'(i_eps) * 64'(r5_hh[63:32]);
            r6_rr   <= r5_rr;
            r6_cs   <= r5_cs;
            r6_ds   <= r5_ds;
            r6_kind <= r5_kind;

            r7_num  <= r6_num;
            r7_den  <= n7_den;
            r7_cs   <= r6_cs;
            r7_ds   <= r6_ds;
            r7_kind <= r6_kind;

            r8_rem  <= DENW'(n8_hi);
            r8_num  <= r7_num[MUW-1:0];
            r8_den  <= r7_den;
            r8_cs   <= r7_cs;
            r8_ds   <= r7_ds;
            r8_kind <= n8_kind;
        end
    end

    assign o_valid = r8_v;
    assign o_rem   = r8_rem;
    assign o_num   = r8_num;
    assign o_den   = r8_den;
    assign o_cs    = r8_cs;
    assign o_ds    = r8_ds;
    assign o_kind  = r8_kind;

endmodule

/* sv/pav_back.sv */
// Back end: coefficient sum t, product t*mu, and setup of the final divide by density.
module pav_back
    import pav_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int MUW       = 79
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [MUW-1:0] i_mu,
    input  logic [31:0]    i_cs,
    input  logic [31:0]    i_ds,
    input  t_kind          i_kind,
    input  logic [30:0]    i_alpha,
    input  logic [30:0]    i_beta,
    input  logic           i_ab_zero,
    output logic           o_valid,
    output logic [31:0]    o_rem,
    output logic [30:0]    o_num,
    output logic [31:0]    o_ds,
    output t_kind          o_kind
);

    localparam int MC  = (MUW + 31) / 32;
    localparam int MPW = 32 * MC;
    localparam int TW  = MUW + 1;
    localparam int TC  = (TW + 31) / 32;
    localparam int TPW = 32 * TC;
    localparam int TFW = MPW + 33;
    localparam int RW  = MPW + 32;
    localparam int PW  = TPW + MPW;
    localparam int QQW = PW - FRAC_BITS;
    localparam int QHW = QQW - 31;

    logic rA_v, rB_v, rC_v, rD_v, rE_v, rF_v;

    // Stage A: partial products of mu*beta and alpha*c.
    logic [MPW-1:0] nA_mu_pad;
    t_kind          nA_kind;

    always_comb begin
        nA_mu_pad = MPW'(i_mu);
        if (i_kind == KIND_CALC && (i_mu == '0 || i_ab_zero)) begin
            nA_kind = KIND_ZERO;
        end else begin
            nA_kind = i_kind;
        end
    end

    logic [63:0]    rA_mb [MC];
    logic [63:0]    rA_ac;
    logic [MUW-1:0] rA_mu;
    logic [31:0]    rA_ds;
    t_kind          rA_kind;

    // Stage B: t = alpha*c + 2*beta*mu, capped where the result must saturate.
    logic [TFW-1:0] nB_t;
    t_kind          nB_kind;

    always_comb begin
        nB_t = TFW'(rA_ac);
        for (int k = 0; k < MC; k++) begin
            nB_t = nB_t + (TFW'(rA_mb[k]) << (32 * k + 1));
        end
        // With mu at least one, a t this large already exceeds the limit.
        if (rA_kind == KIND_CALC && nB_t[TFW-1:TW] != '0) begin
            nB_kind = KIND_SAT;
        end else begin
            nB_kind = rA_kind;
        end
    end

    logic [TW-1:0]  rB_t;
    logic [MUW-1:0] rB_mu;
    logic [31:0]    rB_ds;
    t_kind          rB_kind;

    // Stage C: partial products of t*mu.
    logic [TPW-1:0] nC_t_pad;
    logic [MPW-1:0] nC_mu_pad;

    assign nC_t_pad  = TPW'(rB_t);
    assign nC_mu_pad = MPW'(rB_mu);

    logic [63:0] rC_pp [TC][MC];
    logic [31:0] rC_ds;
    t_kind       rC_kind;

    // Stage D: one row sum per chunk of t.
    logic [RW-1:0] nD_row [TC];

    always_comb begin
        for (int i = 0; i < TC; i++) begin
            nD_row[i] = '0;
            for (int j = 0; j < MC; j++) begin
                nD_row[i] = nD_row[i] + (RW'(rC_pp[i][j]) << (32 * j));
            end
        end
    end

    logic [RW-1:0] rD_row [TC];
    logic [31:0]   rD_ds;
    t_kind         rD_kind;

    // Stage E: full product, scaled down by the fraction bits.
    logic [PW-1:0] nE_p;

    always_comb begin
        nE_p = '0;
        for (int i = 0; i < TC; i++) begin
            nE_p = nE_p + (PW'(rD_row[i]) << (32 * i));
        end
    end

    logic [QQW-1:0] rE_q;
    logic [31:0]    rE_ds;
    t_kind          rE_kind;

    // Stage F: a quotient of 2^31 or more saturates.
    logic  nF_ovf;
    t_kind nF_kind;

    always_comb begin
        nF_ovf = rE_q[QQW-1:31] >= QHW'(rE_ds);
        if (rE_kind == KIND_CALC && nF_ovf) begin
            nF_kind = KIND_SAT;
        end else begin
            nF_kind = rE_kind;
        end
    end

    logic [31:0] rF_rem;
    logic [30:0] rF_num;
    logic [31:0] rF_ds;
    t_kind       rF_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rA_v <= 1'b0;
            rB_v <= 1'b0;
            rC_v <= 1'b0;
            rD_v <= 1'b0;
            rE_v <= 1'b0;
            rF_v <= 1'b0;
        end else if (i_en) begin
            rA_v <= i_valid;
            rB_v <= rA_v;
            rC_v <= rB_v;
            rD_v <= rC_v;
            rE_v <= rD_v;
            rF_v <= rE_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < MC; k++) begin
                rA_mb[k] <= 64'(nA_mu_pad[32 * k +: 32]) * 64'(i_beta);
            end
            rA_ac   <= 64'(i_alpha) * 64'(i_cs);
            rA_mu   <= i_mu;
            rA_ds   <= i_ds;
            rA_kind <= nA_kind;

            rB_t    <= nB_t[TW-1:0];
            rB_mu   <= rA_mu;
            rB_ds   <= rA_ds;
            rB_kind <= nB_kind;

            for (int i = 0; i < TC; i++) begin
                for (int j = 0; j < MC; j++) begin
                    rC_pp[i][j] <= 64'(nC_t_pad[32 * i +: 32]) * 64'(nC_mu_pad[32 * j +: 32]);
                end
            end
            rC_ds   <= rB_ds;
            rC_kind <= rB_kind;

            rD_row  <= nD_row;
            rD_ds   <= rC_ds;
            rD_kind <= rC_kind;

            rE_q    <= nE_p[PW-1:FRAC_BITS];
            rE_ds   <= rD_ds;
            rE_kind <= rD_kind;

            rF_rem  <= rE_q[62:31];
            rF_num  <= rE_q[30:0];
            rF_ds   <= rE_ds;
            rF_kind <= nF_kind;
        end
    end

    assign o_valid = rF_v;
    assign o_rem   = rF_rem;
    assign o_num   = rF_num;
    assign o_ds    = rF_ds;
    assign o_kind  = rF_kind;

endmodule

/* sv/pairwise_artificial_viscosity.sv */
// Top level: configuration registers, the two divider chains and the output register.
// Throughput: one word per cycle while the output is not stalled.
// Every stage is registered; the dividers resolve 1 bit per stage.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
// No clearing pass is needed; the block accepts words as soon as reset is released.
module pairwise_artificial_viscosity
    import pav_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [31:0]   i_rel_pos_x,
    input  logic signed [31:0]   i_rel_pos_y,
    input  logic signed [31:0]   i_rel_pos_z,
    input  logic signed [31:0]   i_rel_vel_x,
    input  logic signed [31:0]   i_rel_vel_y,
    input  logic signed [31:0]   i_rel_vel_z,
    input  logic [30:0]          i_smooth_len_i,
    input  logic [30:0]          i_smooth_len_j,
    input  logic [30:0]          i_sound_i,
    input  logic [30:0]          i_sound_j,
    input  logic [30:0]          i_dens_i,
    input  logic [30:0]          i_dens_j,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_visc_term,
    output logic                 o_saturated,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int MUW  = 63 + FRAC_BITS;
    localparam int DENW = (FRAC_BITS + 67 > 96) ? FRAC_BITS + 67 : 96;
    localparam int SW1  = 66;
    localparam int SW2  = 2;

    logic [30:0] r_alpha, r_beta, r_eps;
    logic        ab_zero;
    logic        en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
            r_beta  <= BETA_RESET;
            r_eps   <= EPS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ALPHA: r_alpha <= i_cfg_data[30:0];
                CFG_BETA:  r_beta  <= i_cfg_data[30:0];
                CFG_EPS:   r_eps   <= i_cfg_data[30:0];
                default:   ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign ab_zero     = (r_alpha == '0) && (r_beta == '0);

    logic r_out_valid;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = r_out_valid && i_stall;

    // Front end into the mu divider.
    logic            d1_v    [MUW+1];
    logic [DENW-1:0] d1_rem  [MUW+1];
    logic [MUW-1:0]  d1_nq   [MUW+1];
    logic [DENW-1:0] d1_dvs  [MUW+1];
    logic [SW1-1:0]  d1_side [MUW+1];

    logic [31:0] f_cs, f_ds;
    t_kind       f_kind;

    pav_front #(
        .FRAC_BITS (FRAC_BITS),
        .MUW       (MUW),
        .DENW      (DENW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_valid),
        .i_rel_pos_x    (i_rel_pos_x),
        .i_rel_pos_y    (i_rel_pos_y),
        .i_rel_pos_z    (i_rel_pos_z),
        .i_rel_vel_x    (i_rel_vel_x),
        .i_rel_vel_y    (i_rel_vel_y),
        .i_rel_vel_z    (i_rel_vel_z),
        .i_smooth_len_i (i_smooth_len_i),
        .i_smooth_len_j (i_smooth_len_j),
        .i_sound_i      (i_sound_i),
        .i_sound_j      (i_sound_j),
        .i_dens_i       (i_dens_i),
        .i_dens_j       (i_dens_j),
        .i_eps          (r_eps),
        .i_ab_zero      (ab_zero),
        .o_valid        (d1_v[0]),
        .o_rem          (d1_rem[0]),
        .o_num          (d1_nq[0]),
        .o_den          (d1_dvs[0]),
        .o_cs           (f_cs),
        .o_ds           (f_ds),
        .o_kind         (f_kind)
    );

    assign d1_side[0] = {f_kind, f_cs, f_ds};

    for (genvar g = 0; g < MUW; g++) begin : g_div_mu
        pav_div_stage #(
            .DW (DENW),
            .QW (MUW),
            .SW (SW1)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (d1_v[g]),
            .i_rem   (d1_rem[g]),
            .i_nq    (d1_nq[g]),
            .i_dvs   (d1_dvs[g]),
            .i_side  (d1_side[g]),
            .o_valid (d1_v[g+1]),
            .o_rem   (d1_rem[g+1]),
            .o_nq    (d1_nq[g+1]),
            .o_dvs   (d1_dvs[g+1]),
            .o_side  (d1_side[g+1])
        );
    end

    // Back end into the divide by density.
    logic        d2_v    [32];
    logic [31:0] d2_rem  [32];
    logic [30:0] d2_nq   [32];
    logic [31:0] d2_dvs  [32];
    logic [SW2-1:0] d2_side [32];

    t_kind b_kind;

    pav_back #(
        .FRAC_BITS (FRAC_BITS),
        .MUW       (MUW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (d1_v[MUW]),
        .i_mu      (d1_nq[MUW]),
        .i_cs      (d1_side[MUW][63:32]),
        .i_ds      (d1_side[MUW][31:0]),
        .i_kind    (t_kind'(d1_side[MUW][65:64])),
        .i_alpha   (r_alpha),
        .i_beta    (r_beta),
        .i_ab_zero (ab_zero),
        .o_valid   (d2_v[0]),
        .o_rem     (d2_rem[0]),
        .o_num     (d2_nq[0]),
        .o_ds      (d2_dvs[0]),
        .o_kind    (b_kind)
    );

    assign d2_side[0] = b_kind;

    for (genvar g = 0; g < 31; g++) begin : g_div_rho
        pav_div_stage #(
            .DW (32),
            .QW (31),
            .SW (SW2)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (d2_v[g]),
            .i_rem   (d2_rem[g]),
            .i_nq    (d2_nq[g]),
            .i_dvs   (d2_dvs[g]),
            .i_side  (d2_side[g]),
            .o_valid (d2_v[g+1]),
            .o_rem   (d2_rem[g+1]),
            .o_nq    (d2_nq[g+1]),
            .o_dvs   (d2_dvs[g+1]),
            .o_side  (d2_side[g+1])
        );
    end

    // Output register.
    t_kind       out_kind;
    logic [31:0] n_visc;
    logic        n_sat;

    assign out_kind = t_kind'(d2_side[31]);

    always_comb begin
        unique case (out_kind)
            KIND_CALC: begin
                n_visc = {1'b0, d2_nq[31]};
                n_sat  = 1'b0;
            end
            KIND_SAT: begin
                n_visc = SAT_VALUE;
                n_sat  = 1'b1;
            end
            default: begin
                n_visc = '0;
                n_sat  = 1'b0;
            end
        endcase
    end

    logic [31:0] r_visc;
    logic        r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d2_v[31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_visc <= n_visc;
            r_sat  <= n_sat;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_visc_term = r_visc;
    assign o_saturated = r_sat;

    // A saturated word always carries the largest positive value.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_visc_term == SAT_VALUE))
        else $error("saturated word without the clip value");

    // The term is never negative.
    a_non_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_visc_term[31])
        else $error("negative viscosity term");

    // A write to the alpha register lands in the next cycle.
    a_cfg_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_index == CFG_ALPHA) |=> (r_alpha == $past(i_cfg_data[30:0])))
        else $error("alpha write lost");

    // Pipeline freezes only while a finished word is held back.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_visc) && r_out_valid))
        else $error("output word changed while stalled");

endmodule

/* test/tb_pairwise_artificial_viscosity.sv */
// Self-checking testbench for the pairwise artificial viscosity pipeline.
module tb_pairwise_artificial_viscosity
    import pav_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC     = 16;
    localparam int LATENCY  = 109 + FRAC;
    localparam int LIMIT    = 400000;
    localparam int N_RANDOM = 1200;

    typedef struct {
        logic [31:0] pos [3];
        logic [31:0] vel [3];
        logic [30:0] h_i, h_j, c_i, c_j, rho_i, rho_j;
    } t_pair;

    typedef struct {
        logic [31:0] visc;
        logic        sat;
    } t_visc;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [31:0]   i_rel_pos_x = '0, i_rel_pos_y = '0, i_rel_pos_z = '0;
    logic signed [31:0]   i_rel_vel_x = '0, i_rel_vel_y = '0, i_rel_vel_z = '0;
    logic [30:0]          i_smooth_len_i = '0, i_smooth_len_j = '0;
    logic [30:0]          i_sound_i = '0, i_sound_j = '0;
    logic [30:0]          i_dens_i = '0, i_dens_j = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic signed [31:0]   o_visc_term;
    logic                 o_saturated;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    pairwise_artificial_viscosity #(.FRAC_BITS(FRAC)) u_top (.*);

    always #10 i_clk = ~i_clk;

    logic [30:0] alpha_q, beta_q, eps_q;
    t_visc       visc_expected [$];
    int          mismatches = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          recv_hold = 0;

    // Exact viscosity term for one pair under the current coefficients.
    function automatic t_visc viscosity_of(t_pair p);
        logic [63:0]  closing, opening, r2, mr, mv, m, hs, cs, ds;
        logic [127:0] num, den, mu, lim, dv, t, need;
        t_visc        res;
        closing = 0;
        opening = 0;
        r2 = 0;
        res.visc = '0;
        res.sat = 1'b0;
        for (int k = 0; k < 3; k++) begin
            mr = {32'd0, p.pos[k][31] ? (~p.pos[k] + 32'd1) : p.pos[k]};
            mv = {32'd0, p.vel[k][31] ? (~p.vel[k] + 32'd1) : p.vel[k]};
            if (p.pos[k][31] != p.vel[k][31]) closing += mr * mv;
            else opening += mr * mv;
            r2 += mr * mr;
        end
        if (closing <= opening) return res;
        m = closing - opening;
        if (r2 == 0) r2 = 1;
        hs = 64'(p.h_i) + 64'(p.h_j);
        cs = 64'(p.c_i) + 64'(p.c_j);
        ds = 64'(p.rho_i) + 64'(p.rho_j);
        if (cs < 2) cs = 2;
        if (ds == 0) begin
            res.visc = SAT_VALUE;
            res.sat = 1'b1;
            return res;
        end
        num = (128'(hs) * 128'(m)) << (FRAC + 1);
        den = (128'(r2) << (FRAC + 2)) + 128'(eps_q) * 128'(hs * hs);
        mu = num / den;
        if (mu == 0 || (alpha_q == 0 && beta_q == 0)) return res;
        lim = 128'(ds) << (31 + FRAC);
        dv = 128'(ds) << FRAC;
        t = 128'(alpha_q) * 128'(cs) + ((mu * 128'(beta_q)) << 1);
        need = (lim + mu - 128'd1) / mu;
        if (mu >= lim || t >= need) begin
            res.visc = SAT_VALUE;
            res.sat = 1'b1;
            return res;
        end
        res.visc = 32'((t * mu) / dv);
        return res;
    endfunction

    task automatic write_coeff(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ALPHA: alpha_q = data[30:0];
            CFG_BETA:  beta_q = data[30:0];
            CFG_EPS:   eps_q = data[30:0];
            default: ;
        endcase
    endtask

    task automatic send_pair(t_pair p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rel_pos_x <= p.pos[0];
        i_rel_pos_y <= p.pos[1];
        i_rel_pos_z <= p.pos[2];
        i_rel_vel_x <= p.vel[0];
        i_rel_vel_y <= p.vel[1];
        i_rel_vel_z <= p.vel[2];
        i_smooth_len_i <= p.h_i;
        i_smooth_len_j <= p.h_j;
        i_sound_i <= p.c_i;
        i_sound_j <= p.c_j;
        i_dens_i <= p.rho_i;
        i_dens_j <= p.rho_j;
        do @(posedge i_clk); while (o_stall);
        visc_expected.push_back(viscosity_of(p));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        wait (visc_expected.size() == 0);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // Values of random magnitude so that tiny, typical and huge operands all occur.
    function automatic logic [31:0] rnd_word(int bits);
        return $urandom & (32'hFFFF_FFFF >> (32 - bits));
    endfunction

    function automatic t_pair rnd_pair();
        t_pair p;
        int    pw;
        bit    closing;
        pw = $urandom_range(4, 32);
        closing = $urandom_range(99) < 80;
        for (int k = 0; k < 3; k++) begin
            p.pos[k] = rnd_word(pw);
            p.vel[k] = rnd_word($urandom_range(1, 32));
            if ($urandom_range(1)) p.pos[k] = -p.pos[k];
            // Mostly make the velocity point against the separation.
            if (closing) p.vel[k] = p.pos[k][31] ? p.vel[k] & 32'h7FFF_FFFF
                                                 : -(p.vel[k] & 32'h7FFF_FFFF);
            else if ($urandom_range(1)) p.vel[k] = -p.vel[k];
        end
        p.h_i = 31'(rnd_word($urandom_range(1, 31)));
        p.h_j = 31'(rnd_word($urandom_range(1, 31)));
        p.c_i = 31'(rnd_word($urandom_range(1, 31)));
        p.c_j = 31'(rnd_word($urandom_range(1, 31)));
        p.rho_i = 31'(rnd_word($urandom_range(1, 31)));
        p.rho_j = 31'(rnd_word($urandom_range(1, 31)));
        if ($urandom_range(49) == 0) {p.rho_i, p.rho_j} = '0;
        return p;
    endfunction

    function automatic t_pair make_pair(logic [31:0] r, logic [31:0] v, logic [30:0] h,
                                        logic [30:0] c, logic [30:0] rho);
        t_pair p;
        p.pos = '{r, r, r};
        p.vel = '{v, v, v};
        p.h_i = h; p.h_j = h;
        p.c_i = c; p.c_j = c;
        p.rho_i = rho; p.rho_j = rho;
        return p;
    endfunction

    task automatic test_special_cases();
        t_pair p;
        send_pair(make_pair(0, 0, 0, 0, 0));
        send_pair(make_pair(32'h0001_0000, 32'h0001_0000, 31'h8000, 31'h10000, 31'h10000));
        send_pair(make_pair(32'h0001_0000, 32'hFFFF_0000, 31'h8000, 31'h10000, 31'h10000));
        // Tiny separation and tiny sound speed.
        send_pair(make_pair(32'h0000_0001, 32'h8000_0000, 31'h7FFF_FFFF, 0, 31'h7FFF_FFFF));
        send_pair(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                            31'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 0, 31'h7FFF_FFFF, 1));
        // Approaching pair with zero mean density saturates.
        send_pair(make_pair(32'h0001_0000, 32'hFFFF_0000, 31'h10000, 31'h10000, 0));
        // Overflow: fast approach, near-zero density.
        send_pair(make_pair(32'h0000_0100, 32'h8000_0001, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1));
        p = make_pair(32'h0002_0000, 32'hFFFE_0000, 31'h2_0000, 31'h5_0000, 31'h1_0000);
        p.rho_j = 0;
        p.c_j = 0;
        send_pair(p);
        p.pos[1] = 32'hFFFF_FFFF;
        p.vel[2] = 32'h1234_5678;
        p.h_j = 31'h5555_5555;
        p.rho_j = 31'h2AAA_AAAA;
        send_pair(p);
        for (int n = 0; n < 10; n++) send_pair(rnd_pair());
        drain();
    endtask

    task automatic test_coeff_settings();
        logic [31:0] val [4] = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0001_0000};
        foreach (val[s]) begin
            write_coeff(CFG_ALPHA, val[s]);
            write_coeff(CFG_BETA, val[(s + 1) % 4]);
            write_coeff(CFG_EPS, val[(s + 2) % 4]);
            // An index past the last register is ignored.
            write_coeff(2'd3, $urandom);
            for (int n = 0; n < 40; n++) send_pair(rnd_pair());
            drain();
        end
        write_coeff(CFG_ALPHA, 0);
        write_coeff(CFG_BETA, 0);
        for (int n = 0; n < 20; n++) send_pair(rnd_pair());
        drain();
        write_coeff(CFG_ALPHA, ALPHA_RESET);
        write_coeff(CFG_BETA, BETA_RESET);
        write_coeff(CFG_EPS, EPS_RESET);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_hold = 400;
        for (int n = 0; n < 300; n++) send_pair(rnd_pair());
        drain();
        for (int n = 0; n < 30; n++) send_pair(rnd_pair());
        drain();
    endtask

    task automatic test_random_stream();
        int modes [3][2] = '{'{23, 79}, '{79, 23}, '{0, 0}};
        foreach (modes[m]) begin
            send_idle_pct = modes[m][0];
            recv_idle_pct = modes[m][1];
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                // The guard changes only once every word in flight has come out.
                if (n % 100 == 0) begin
                    drain();
                    write_coeff(CFG_EPS, $urandom_range(0, 4000));
                end
                send_pair(rnd_pair());
            end
            drain();
        end
    endtask

    // Receiver: random stall, a long hold when requested, and the result check.
    always @(posedge i_clk) begin
        t_visc want;
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= $urandom_range(99) < recv_idle_pct;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (visc_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: visc=%h sat=%b",
                                               o_visc_term, o_saturated);
            end else begin
                want = visc_expected.pop_front();
                if (o_visc_term !== want.visc || o_saturated !== want.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected visc=%h sat=%b, got visc=%h sat=%b",
                                 want.visc, want.sat, o_visc_term, o_saturated);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        alpha_q = ALPHA_RESET;
        beta_q = BETA_RESET;
        eps_q = EPS_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_cases();
        test_coeff_settings();
        test_backpressure();
        test_random_stream();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* pairwise_artificial_viscosity.f */
sv/pav_pkg.sv
sv/pav_div_stage.sv
sv/pav_front.sv
sv/pav_back.sv
sv/pairwise_artificial_viscosity.sv
test/tb_pairwise_artificial_viscosity.sv
